>>> rtl/srag_pkg.sv
// ----------------------------------------------------------------------------
// srag_pkg
// Shared constants and types for the strided resample address generator.
// ----------------------------------------------------------------------------
package srag_pkg;

    localparam int EPI        = 4;     // elements per work item
    localparam int AW         = 32;    // address width
    localparam int POS_W      = 24;
    localparam int BATCH_W    = 16;
    localparam int STRIDE_W   = 24;
    localparam int STEP_W     = 8;
    localparam int DW         = 24;    // divider operand width
    localparam int DIV_BPS    = 2;     // quotient bits per divider stage
    localparam int DIV_STAGES = DW / DIV_BPS;
    localparam int EPI_SH     = $clog2(EPI);
    localparam int CNT_W      = (EPI > 1) ? $clog2(EPI) : 1;
    localparam int PADDR_W    = 5;

    typedef enum logic [2:0] {
        REG_DCS  = 3'd0,
        REG_DRS  = 3'd1,
        REG_DBS  = 3'd2,
        REG_SCS  = 3'd3,
        REG_SRS  = 3'd4,
        REG_SBS  = 3'd5,
        REG_STPX = 3'd6,
        REG_STPY = 3'd7
    } t_reg_idx;

    // sideband that travels next to the dividers
    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] pos;
        logic [AW-1:0]    pb_d;
        logic [AW-1:0]    pb_s;
        logic [DW-1:0]    chan;
    } t_side;

endpackage

>>> rtl/srag_div.sv
// ----------------------------------------------------------------------------
// srag_div
// Pipelined restoring divider, DIV_BPS quotient bits per stage.
// A zero divisor gives quotient 0 and remainder equal to the dividend.
// ----------------------------------------------------------------------------
module srag_div (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [srag_pkg::DW-1:0] i_num,
    input  logic [srag_pkg::DW-1:0] i_den,
    output logic [srag_pkg::DW-1:0] o_quot,
    output logic [srag_pkg::DW-1:0] o_rem
);

    logic [srag_pkg::DW:0]   r_rem [srag_pkg::DIV_STAGES];
    logic [srag_pkg::DW-1:0] r_nq  [srag_pkg::DIV_STAGES];
    logic [srag_pkg::DW:0]   n_rem [srag_pkg::DIV_STAGES];
    logic [srag_pkg::DW-1:0] n_nq  [srag_pkg::DIV_STAGES];

    always_comb begin
        logic [srag_pkg::DW:0]   rem;
        logic [srag_pkg::DW-1:0] nq;
        for (int s = 0; s < srag_pkg::DIV_STAGES; s++) begin
            if (s == 0) begin
                rem = '0;
                nq  = i_num;
            end else begin
                rem = r_rem[s-1];
                nq  = r_nq[s-1];
            end
            for (int b = 0; b < srag_pkg::DIV_BPS; b++) begin
                rem = {rem[srag_pkg::DW-1:0], nq[srag_pkg::DW-1]};
                nq  = {nq[srag_pkg::DW-2:0], 1'b0};
                if (rem >= {1'b0, i_den}) begin
                    rem   = rem - {1'b0, i_den};
                    nq[0] = 1'b1;
                end
            end
            n_rem[s] = rem;
            n_nq[s]  = nq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < srag_pkg::DIV_STAGES; s++) begin
                r_rem[s] <= n_rem[s];
                r_nq[s]  <= n_nq[s];
            end
        end
    end

    // divisor is static config, so the zero case is fixed up at the output;
    // with a zero divisor the remainder chain simply collects the dividend
    always_comb begin
        if (i_den == '0) begin
            o_quot = '0;
            o_rem  = r_rem[srag_pkg::DIV_STAGES-1][srag_pkg::DW-1:0];
        end else begin
            o_quot = r_nq[srag_pkg::DIV_STAGES-1];
            o_rem  = r_rem[srag_pkg::DIV_STAGES-1][srag_pkg::DW-1:0];
        end
    end

endmodule

>>> rtl/strided_resample_address_gen.sv
// ----------------------------------------------------------------------------
// strided_resample_address_gen
// Turns a dense position and batch index into a run of dense/strided
// element address pairs.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry one word (dense position, batch).
// Output channel: o_valid / i_stall carry one address pair per word, EPI
// (4) words per input word, the last flagged by o_last_element.
// Pipeline: 1 input stage, 12 + 12 divider stages, 3 multiply/add stages,
// 1 output register. The two divisions are pipelined, so a new input word can
// enter every cycle unless the pipeline is frozen; the output register emits
// one pair per cycle unless the receiver stalls, so the sustained input
// rate is set by the output port, which sends EPI pairs per input word.
// When the receiver stalls, the output word holds; the whole pipeline freezes
// while M3 holds a word that the output cannot take yet; o_stall then rises.
// Reset (synchronous, i_rst_n low) empties the pipeline and loads the
// register defaults. Registers are written through the APB port and must
// only change while the block is empty.
// ----------------------------------------------------------------------------
module strided_resample_address_gen (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [srag_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [srag_pkg::POS_W-1:0]    i_dense_position,
    input  logic [srag_pkg::BATCH_W-1:0]  i_batch_index,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [srag_pkg::AW-1:0]       o_dense_address,
    output logic [srag_pkg::AW-1:0]       o_sparse_address,
    output logic                          o_last_element
);

    // config registers
    logic [srag_pkg::STRIDE_W-1:0] r_dcs, r_drs;
    logic [srag_pkg::AW-1:0]       r_dbs, r_scs, r_srs, r_sbs;
    logic [srag_pkg::STEP_W-1:0]   r_stpx, r_stpy;
    srag_pkg::t_reg_idx            w_idx;

    assign pready = 1'b1;
    assign w_idx  = srag_pkg::t_reg_idx'(paddr[srag_pkg::PADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcs  <= srag_pkg::STRIDE_W'(4);
            r_drs  <= srag_pkg::STRIDE_W'(4);
            r_dbs  <= '0;
            r_scs  <= '0;
            r_srs  <= '0;
            r_sbs  <= '0;
            r_stpx <= srag_pkg::STEP_W'(1);
            r_stpy <= srag_pkg::STEP_W'(1);
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                srag_pkg::REG_DCS:  r_dcs  <= pwdata[srag_pkg::STRIDE_W-1:0];
                srag_pkg::REG_DRS:  r_drs  <= pwdata[srag_pkg::STRIDE_W-1:0];
                srag_pkg::REG_DBS:  r_dbs  <= pwdata;
                srag_pkg::REG_SCS:  r_scs  <= pwdata;
                srag_pkg::REG_SRS:  r_srs  <= pwdata;
                srag_pkg::REG_SBS:  r_sbs  <= pwdata;
                srag_pkg::REG_STPX: r_stpx <= pwdata[srag_pkg::STEP_W-1:0];
                srag_pkg::REG_STPY: r_stpy <= pwdata[srag_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            srag_pkg::REG_DCS:  prdata = 32'(r_dcs);
            srag_pkg::REG_DRS:  prdata = 32'(r_drs);
            srag_pkg::REG_DBS:  prdata = r_dbs;
            srag_pkg::REG_SCS:  prdata = r_scs;
            srag_pkg::REG_SRS:  prdata = r_srs;
            srag_pkg::REG_SBS:  prdata = r_sbs;
            srag_pkg::REG_STPX: prdata = 32'(r_stpx);
            srag_pkg::REG_STPY: prdata = 32'(r_stpy);
            default:            prdata = '0;
        endcase
    end

    // flow control: all stages before the output register move together
    logic                     r_o_valid;
    logic                     r_m3_valid;
    logic [srag_pkg::CNT_W-1:0] r_o_cnt;
    logic                     w_o_last;
    logic                     w_take;
    logic                     w_adv;

    assign w_o_last = (r_o_cnt == srag_pkg::CNT_W'(srag_pkg::EPI - 1));
    assign w_take   = !r_o_valid || (!i_stall && w_o_last);
    assign w_adv    = !r_m3_valid || w_take;
    assign o_stall  = !w_adv;

    // input stage: batch products
    logic                        r_a_valid;
    logic [srag_pkg::POS_W-1:0]  r_a_pos;
    logic [srag_pkg::AW-1:0]     r_a_pbd, r_a_pbs;
    logic [47:0]                 w_pbd, w_pbs;

    assign w_pbd = 48'(i_batch_index) * 48'(r_dbs);
    assign w_pbs = 48'(i_batch_index) * 48'(r_sbs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_pos <= i_dense_position;
            r_a_pbd <= w_pbd[srag_pkg::AW-1:0];
            r_a_pbs <= w_pbs[srag_pkg::AW-1:0];
        end
    end

    // channel division then row division
    logic [srag_pkg::DW-1:0] w_den1, w_den2;
    logic [srag_pkg::DW-1:0] w_chan, w_pix, w_row, w_col;

    assign w_den1 = srag_pkg::DW'(r_dcs >> srag_pkg::EPI_SH);
    assign w_den2 = srag_pkg::DW'(r_drs >> srag_pkg::EPI_SH);

    srag_div u_div_chan (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_num  (srag_pkg::DW'(r_a_pos)),
        .i_den  (w_den1),
        .o_quot (w_chan),
        .o_rem  (w_pix)
    );

    srag_div u_div_row (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_num  (w_pix),
        .i_den  (w_den2),
        .o_quot (w_row),
        .o_rem  (w_col)
    );

    srag_pkg::t_side r_sd1 [srag_pkg::DIV_STAGES];
    srag_pkg::t_side r_sd2 [srag_pkg::DIV_STAGES];
    srag_pkg::t_side w_sd1_in, w_sd2_in, w_sd_out;

    always_comb begin
        w_sd1_in       = '0;
        w_sd1_in.valid = r_a_valid;
        w_sd1_in.pos   = r_a_pos;
        w_sd1_in.pb_d  = r_a_pbd;
        w_sd1_in.pb_s  = r_a_pbs;
        w_sd2_in       = r_sd1[srag_pkg::DIV_STAGES-1];
        w_sd2_in.chan  = w_chan;
        w_sd_out       = r_sd2[srag_pkg::DIV_STAGES-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < srag_pkg::DIV_STAGES; s++) begin
                r_sd1[s].valid <= 1'b0;
                r_sd2[s].valid <= 1'b0;
            end
        end else if (w_adv) begin
            r_sd1[0] <= w_sd1_in;
            r_sd2[0] <= w_sd2_in;
            for (int s = 1; s < srag_pkg::DIV_STAGES; s++) begin
                r_sd1[s] <= r_sd1[s-1];
                r_sd2[s] <= r_sd2[s-1];
            end
        end
    end

    // M1: products of the split position
    logic                    r_m1_valid;
    logic [srag_pkg::AW-1:0] r_m1_dbase, r_m1_pbs, r_m1_pch, r_m1_pry, r_m1_pcx;
    logic [55:0]             w_pch;
    logic [31:0]             w_pry, w_pcx;

    assign w_pch = 56'(w_sd_out.chan) * 56'(r_scs);
    assign w_pry = 32'(w_row) * 32'(r_stpy);
    assign w_pcx = 32'(w_col) * 32'(r_stpx);

    // M2: row term and partial sum
    logic                    r_m2_valid;
    logic [srag_pkg::AW-1:0] r_m2_dbase, r_m2_sum, r_m2_pr;
    logic [63:0]             w_pr;

    assign w_pr = 64'(r_m1_pry) * 64'(r_srs);

    // M3: final base addresses
    logic [srag_pkg::AW-1:0] r_m3_dbase, r_m3_sbase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_valid <= 1'b0;
            r_m2_valid <= 1'b0;
            r_m3_valid <= 1'b0;
        end else if (w_adv) begin
            r_m1_valid <= w_sd_out.valid;
            r_m2_valid <= r_m1_valid;
            r_m3_valid <= r_m2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m1_dbase <= w_sd_out.pb_d
                        + srag_pkg::AW'(w_sd_out.pos) * srag_pkg::AW'(srag_pkg::EPI);
            r_m1_pbs   <= w_sd_out.pb_s;
            r_m1_pch   <= w_pch[srag_pkg::AW-1:0];
            r_m1_pry   <= w_pry;
            r_m1_pcx   <= w_pcx * srag_pkg::AW'(srag_pkg::EPI);
            r_m2_dbase <= r_m1_dbase;
            r_m2_sum   <= r_m1_pbs + r_m1_pch + r_m1_pcx;
            r_m2_pr    <= w_pr[srag_pkg::AW-1:0];
            r_m3_dbase <= r_m2_dbase;
            r_m3_sbase <= r_m2_sum + r_m2_pr;
        end
    end

    // output register: walks the run of EPI pairs
    logic [srag_pkg::AW-1:0] r_o_dadr, r_o_sadr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_o_cnt   <= '0;
        end else if (w_take) begin
            r_o_valid <= r_m3_valid;
            r_o_cnt   <= '0;
        end else if (!i_stall) begin
            r_o_cnt   <= r_o_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_o_dadr <= r_m3_dbase;
            r_o_sadr <= r_m3_sbase;
        end else if (!i_stall) begin
            r_o_dadr <= r_o_dadr + 1'b1;
            r_o_sadr <= r_o_sadr + srag_pkg::AW'(r_stpx);
        end
    end

    assign o_valid          = r_o_valid;
    assign o_dense_address  = r_o_dadr;
    assign o_sparse_address = r_o_sadr;
    assign o_last_element   = w_o_last;

endmodule

>>> rtl/srag_checker.sv
// ----------------------------------------------------------------------------
// srag_port_checks
// Port-level checks for the strided resample address generator.
// ----------------------------------------------------------------------------
module srag_port_checks (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [srag_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    input  logic [31:0]                   prdata,
    input  logic                          pready,
    input  logic                          i_valid,
    input  logic                          o_stall,
    input  logic [srag_pkg::POS_W-1:0]    i_dense_position,
    input  logic [srag_pkg::BATCH_W-1:0]  i_batch_index,
    input  logic                          o_valid,
    input  logic                          i_stall,
    input  logic [srag_pkg::AW-1:0]       o_dense_address,
    input  logic [srag_pkg::AW-1:0]       o_sparse_address,
    input  logic                          o_last_element
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_dense_address)
                               && $stable(o_sparse_address)
                               && $stable(o_last_element))
        else $error("stalled output word changed");

    // inside a run, the next word follows at once with dense address + 1
    a_run_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_element |=>
            o_valid && (o_dense_address == $past(o_dense_address) + 32'd1))
        else $error("run broken or dense address did not step");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_ready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

endmodule

bind strided_resample_address_gen srag_port_checks u_srag_port_checks (.*);
